FILE: src/fsp_pkg.sv
`default_nettype none
package fsp_pkg;

    // parser mode
    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_WIDTH,
        MODE_PREC,
        MODE_PEND_H,
        MODE_PEND_L
    } mode_t;

    // format bytes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_J     = 8'h6A;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_Z     = 8'h7A;

    // length modifier bit positions
    localparam int LN_H  = 0;
    localparam int LN_HH = 1;
    localparam int LN_L  = 2;
    localparam int LN_LL = 3;
    localparam int LN_J  = 4;
    localparam int LN_Z  = 5;

    // fixed-width part of one result beat
    typedef struct packed {
        logic       left_align;
        logic       force_sign;
        logic       alt_form;
        logic       space_sign;
        logic       zero_pad;
        logic       has_precision;
        logic [5:0] length_mask;
        logic [7:0] conversion;
        logic       found;
    } res_ctl_t;

endpackage
`default_nettype wire

FILE: src/fsp_in_buf.sv
`default_nettype none
module fsp_in_buf (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [7:0] in_char,
    output logic            in_stall,
    input  wire logic       take,
    output logic            buf_valid,
    output logic [7:0]      buf_char
);
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] char_reg;
    logic       load;

    // hold the byte until the parser takes it
    assign in_stall   = valid_reg && !take;
    assign load       = in_valid && !in_stall;
    assign valid_next = load || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= in_char;
        end
    end

    assign buf_valid = valid_reg;
    assign buf_char  = char_reg;

endmodule
`default_nettype wire

FILE: src/fsp_engine.sv
`default_nettype none
module fsp_engine #(
    parameter int VALUE_BITS = 16,
    parameter int INDEX_BITS = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  buf_valid,
    input  wire logic [7:0]            buf_char,
    input  wire logic                  out_free,
    output logic                       take,
    output logic                       load,
    output fsp_pkg::res_ctl_t          res_ctl,
    output logic [VALUE_BITS-1:0]      res_width,
    output logic [VALUE_BITS-1:0]      res_prec,
    output logic [INDEX_BITS-1:0]      res_pos
);
    import fsp_pkg::*;

    mode_t                 mode_reg,    mode_next;
    logic [4:0]            flags_reg,   flags_next;
    logic [VALUE_BITS-1:0] width_reg,   width_next;
    logic                  prec_on_reg, prec_on_next;
    logic [VALUE_BITS-1:0] prec_reg,    prec_next;
    logic [5:0]            len_reg,     len_next;
    logic [INDEX_BITS-1:0] idx_reg,     idx_next;
    logic                  emit;
    logic [7:0]            conv;
    logic                  found;

    // acc * 10 + digit, clamped to all ones
    function automatic logic [VALUE_BITS-1:0] add_digit(
        input logic [VALUE_BITS-1:0] acc,
        input logic [7:0]            c
    );
        logic [VALUE_BITS+3:0] prod;
        prod = ({4'b0, acc} << 3) + ({4'b0, acc} << 1)
             + {{VALUE_BITS{1'b0}}, c[3:0]};
        if (prod[VALUE_BITS+3:VALUE_BITS] != 4'b0)
            add_digit = '1;
        else
            add_digit = prod[VALUE_BITS-1:0];
    endfunction

    // one byte of the spec
    always_comb
    begin
        logic is_digit;
        logic fall;
        mode_next    = mode_reg;
        flags_next   = flags_reg;
        width_next   = width_reg;
        prec_on_next = prec_on_reg;
        prec_next    = prec_reg;
        len_next     = len_reg;
        emit         = 1'b0;
        conv         = CH_NUL;
        found        = 1'b0;
        fall         = 1'b0;
        is_digit     = (buf_char >= CH_ZERO) && (buf_char <= CH_NINE);

        // mode-specific handling, may fall through to plain decode
        unique case (mode_reg)
            MODE_PEND_H:
            begin
                mode_next = MODE_IDLE;
                if (buf_char == CH_H)
                    len_next[LN_HH] = 1'b1;
                else
                begin
                    len_next[LN_H] = 1'b1;
                    fall = 1'b1;
                end
            end
            MODE_PEND_L:
            begin
                mode_next = MODE_IDLE;
                if (buf_char == CH_L)
                    len_next[LN_LL] = 1'b1;
                else
                begin
                    len_next[LN_L] = 1'b1;
                    fall = 1'b1;
                end
            end
            MODE_WIDTH:
            begin
                if (is_digit)
                    width_next = add_digit(width_reg, buf_char);
                else
                begin
                    mode_next = MODE_IDLE;
                    fall = 1'b1;
                end
            end
            MODE_PREC:
            begin
                if (is_digit)
                    prec_next = add_digit(prec_reg, buf_char);
                else if (buf_char != CH_DOT)
                begin
                    mode_next = MODE_IDLE;
                    fall = 1'b1;
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
                fall = 1'b1;
            end
        endcase

        // plain decode from idle
        if (fall)
        begin
            priority if (buf_char == CH_NUL)
                emit = 1'b1;
            else if (buf_char == CH_MINUS)
                flags_next[0] = 1'b1;
            else if (buf_char == CH_PLUS)
                flags_next[1] = 1'b1;
            else if (buf_char == CH_HASH)
                flags_next[2] = 1'b1;
            else if (buf_char == CH_SPACE)
                flags_next[3] = 1'b1;
            else if (is_digit)
            begin
                if (buf_char == CH_ZERO)
                    flags_next[4] = 1'b1;
                else
                    width_next = add_digit(width_reg, buf_char);
                mode_next = MODE_WIDTH;
            end
            else if (buf_char == CH_DOT)
            begin
                prec_on_next = 1'b1;
                mode_next = MODE_PREC;
            end
            else if (buf_char == CH_H)
                mode_next = MODE_PEND_H;
            else if (buf_char == CH_L)
                mode_next = MODE_PEND_L;
            else if (buf_char == CH_J)
                len_next[LN_J] = 1'b1;
            else if (buf_char == CH_Z)
                len_next[LN_Z] = 1'b1;
            else
            begin
                emit  = 1'b1;
                conv  = buf_char;
                found = 1'b1;
            end
        end
    end

    // saturating byte position
    assign idx_next = (idx_reg == '1) ? idx_reg : idx_reg + 1'b1;

    // a result beat waits for the output register to be free
    assign take = buf_valid && (!emit || out_free);
    assign load = take && emit;

    // result beat from the updated state
    assign res_ctl.left_align    = flags_next[0];
    assign res_ctl.force_sign    = flags_next[1];
    assign res_ctl.alt_form      = flags_next[2];
    assign res_ctl.space_sign    = flags_next[3];
    assign res_ctl.zero_pad      = flags_next[4];
    assign res_ctl.has_precision = prec_on_next;
    assign res_ctl.length_mask   = len_next;
    assign res_ctl.conversion    = conv;
    assign res_ctl.found         = found;
    assign res_width             = width_next;
    assign res_prec              = prec_next;
    assign res_pos               = idx_reg;

    // parser state, cleared after each spec
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            flags_reg   <= '0;
            width_reg   <= '0;
            prec_on_reg <= 1'b0;
            prec_reg    <= '0;
            len_reg     <= '0;
            idx_reg     <= '0;
        end
        else if (take)
        begin
            if (emit)
            begin
                mode_reg    <= MODE_IDLE;
                flags_reg   <= '0;
                width_reg   <= '0;
                prec_on_reg <= 1'b0;
                prec_reg    <= '0;
                len_reg     <= '0;
                idx_reg     <= '0;
            end
            else
            begin
                mode_reg    <= mode_next;
                flags_reg   <= flags_next;
                width_reg   <= width_next;
                prec_on_reg <= prec_on_next;
                prec_reg    <= prec_next;
                len_reg     <= len_next;
                idx_reg     <= idx_next;
            end
        end
    end

    // state clears once a spec ends
    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (mode_reg == MODE_IDLE) && (idx_reg == '0) && (flags_reg == '0))
        else $error("parser state not cleared after spec end");

    // position only grows within a spec
    a_pos_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !emit) |=> (idx_reg >= $past(idx_reg)))
        else $error("byte position went backward");

    // precision mode implies a dot was seen
    a_prec_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_PREC) |-> prec_on_reg)
        else $error("precision mode without precision flag");

endmodule
`default_nettype wire

FILE: src/fsp_out_reg.sv
`default_nettype none
module fsp_out_reg #(
    parameter int VALUE_BITS = 16,
    parameter int INDEX_BITS = 8
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   load,
    input  wire fsp_pkg::res_ctl_t      res_ctl,
    input  wire logic [VALUE_BITS-1:0]  res_width,
    input  wire logic [VALUE_BITS-1:0]  res_prec,
    input  wire logic [INDEX_BITS-1:0]  res_pos,
    input  wire logic                   out_stall,
    output logic                        out_free,
    output logic                        out_valid,
    output fsp_pkg::res_ctl_t           out_ctl,
    output logic [VALUE_BITS-1:0]       out_width,
    output logic [VALUE_BITS-1:0]       out_prec,
    output logic [INDEX_BITS-1:0]       out_pos
);
    import fsp_pkg::*;

    logic                  valid_reg;
    logic                  valid_next;
    res_ctl_t              ctl_reg;
    logic [VALUE_BITS-1:0] width_reg;
    logic [VALUE_BITS-1:0] prec_reg;
    logic [INDEX_BITS-1:0] pos_reg;

    // free when empty or the held beat leaves this cycle
    assign out_free   = !valid_reg || !out_stall;
    assign valid_next = load || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ctl_reg   <= res_ctl;
            width_reg <= res_width;
            prec_reg  <= res_prec;
            pos_reg   <= res_pos;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_width = width_reg;
    assign out_prec  = prec_reg;
    assign out_pos   = pos_reg;

endmodule
`default_nettype wire

FILE: src/format_spec_parser.sv
`default_nettype none
// Parses a printf conversion spec one byte per beat, starting with the byte
// after the percent sign, and returns one result beat when a conversion byte
// or a NUL ends the spec. A new byte is taken every cycle; a result appears
// in the cycle after its ending byte is taken from the input register (the
// parse step writes the result register as it takes that byte) and is held
// until taken. Only a stalled result that blocks a further ending byte holds
// up the input side.
module format_spec_parser #(
    parameter int VALUE_BITS = 16,
    parameter int INDEX_BITS = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [7:0]            in_char,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       left_align,
    output logic                       force_sign,
    output logic                       alt_form,
    output logic                       space_sign,
    output logic                       zero_pad,
    output logic [VALUE_BITS-1:0]      field_width,
    output logic                       has_precision,
    output logic [VALUE_BITS-1:0]      precision_value,
    output logic [5:0]                 length_mask,
    output logic [7:0]                 conversion,
    output logic                       found,
    output logic [INDEX_BITS-1:0]      position
);
    import fsp_pkg::*;

    logic                  buf_valid;
    logic [7:0]            buf_char;
    logic                  take;
    logic                  load;
    logic                  out_free;
    res_ctl_t              res_ctl;
    res_ctl_t              out_ctl;
    logic [VALUE_BITS-1:0] res_width;
    logic [VALUE_BITS-1:0] res_prec;
    logic [INDEX_BITS-1:0] res_pos;

    // input register
    fsp_in_buf u_in_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_char   (in_char),
        .in_stall  (in_stall),
        .take      (take),
        .buf_valid (buf_valid),
        .buf_char  (buf_char)
    );

    // parse step and spec state
    fsp_engine #(
        .VALUE_BITS (VALUE_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .buf_valid (buf_valid),
        .buf_char  (buf_char),
        .out_free  (out_free),
        .take      (take),
        .load      (load),
        .res_ctl   (res_ctl),
        .res_width (res_width),
        .res_prec  (res_prec),
        .res_pos   (res_pos)
    );

    // result register
    fsp_out_reg #(
        .VALUE_BITS (VALUE_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .res_ctl   (res_ctl),
        .res_width (res_width),
        .res_prec  (res_prec),
        .res_pos   (res_pos),
        .out_stall (out_stall),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_ctl   (out_ctl),
        .out_width (field_width),
        .out_prec  (precision_value),
        .out_pos   (position)
    );

    // unpack the result beat
    assign left_align    = out_ctl.left_align;
    assign force_sign    = out_ctl.force_sign;
    assign alt_form      = out_ctl.alt_form;
    assign space_sign    = out_ctl.space_sign;
    assign zero_pad      = out_ctl.zero_pad;
    assign has_precision = out_ctl.has_precision;
    assign length_mask   = out_ctl.length_mask;
    assign conversion    = out_ctl.conversion;
    assign found         = out_ctl.found;

endmodule
`default_nettype wire

FILE: bench/format_spec_parser_tb.sv
module format_spec_parser_tb;
    import fsp_pkg::*;

    localparam int VALUE_BITS = 16;
    localparam int INDEX_BITS = 8;
    localparam longint unsigned VALUE_MAX = (64'd1 << VALUE_BITS) - 1;
    localparam int RANDOM_BYTES = 1350;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = 10;

    // one finished conversion spec
    typedef struct {
        logic                  left_align;
        logic                  force_sign;
        logic                  alt_form;
        logic                  space_sign;
        logic                  zero_pad;
        logic [VALUE_BITS-1:0] field_width;
        logic                  has_precision;
        logic [VALUE_BITS-1:0] precision_value;
        logic [5:0]            length_mask;
        logic [7:0]            conversion;
        logic                  found;
        logic [INDEX_BITS-1:0] position;
    } spec_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [7:0]            in_char = 8'h00;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  left_align;
    logic                  force_sign;
    logic                  alt_form;
    logic                  space_sign;
    logic                  zero_pad;
    logic [VALUE_BITS-1:0] field_width;
    logic                  has_precision;
    logic [VALUE_BITS-1:0] precision_value;
    logic [5:0]            length_mask;
    logic [7:0]            conversion;
    logic                  found;
    logic [INDEX_BITS-1:0] position;

    format_spec_parser #(
        .VALUE_BITS(VALUE_BITS),
        .INDEX_BITS(INDEX_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_char(in_char),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .left_align(left_align),
        .force_sign(force_sign),
        .alt_form(alt_form),
        .space_sign(space_sign),
        .zero_pad(zero_pad),
        .field_width(field_width),
        .has_precision(has_precision),
        .precision_value(precision_value),
        .length_mask(length_mask),
        .conversion(conversion),
        .found(found),
        .position(position)
    );

    // format bytes waiting to be sent and specs waiting to come back
    logic [7:0]   format_bytes[$];
    spec_result_t parsed_specs[$];
    int           total_bytes = 0;
    int           bytes_taken = 0;
    int           specs_checked = 0;
    int           error_count = 0;
    int           cycle_count = 0;
    bit           send_calm = 1'b0;
    bit           recv_calm = 1'b0;
    string        conv_letters = "diouxXfFeEgGaAcspn%";
    string        filler_chars = "-+# #0123456789.jz";

    // parser state as predicted
    mode_t                 spec_mode;
    logic                  minus_seen;
    logic                  plus_seen;
    logic                  hash_seen;
    logic                  space_seen;
    logic                  zero_seen;
    logic [VALUE_BITS-1:0] width_sum;
    logic                  prec_on;
    logic [VALUE_BITS-1:0] prec_sum;
    logic [5:0]            len_bits;
    logic [INDEX_BITS-1:0] byte_pos;

    initial begin
        forever #10 clk = ~clk;
    end

    function automatic bit is_digit(logic [7:0] c);
        return c inside {[CH_ZERO:CH_NINE]};
    endfunction

    // decimal accumulate, clamped at the top of the value range
    function automatic logic [VALUE_BITS-1:0] add_digit(logic [VALUE_BITS-1:0] acc,
                                                        logic [7:0] c);
        longint unsigned sum;
        sum = longint'(acc) * 10 + longint'(c - CH_ZERO);
        return (sum > VALUE_MAX) ? '1 : sum[VALUE_BITS-1:0];
    endfunction

    function automatic int pick_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic clear_spec();
        spec_mode = MODE_IDLE;
        minus_seen = 1'b0;
        plus_seen = 1'b0;
        hash_seen = 1'b0;
        space_seen = 1'b0;
        zero_seen = 1'b0;
        width_sum = '0;
        prec_on = 1'b0;
        prec_sum = '0;
        len_bits = '0;
        byte_pos = '0;
    endtask

    task automatic close_spec(logic [7:0] conv, logic hit);
        spec_result_t r;
        r.left_align = minus_seen;
        r.force_sign = plus_seen;
        r.alt_form = hash_seen;
        r.space_sign = space_seen;
        r.zero_pad = zero_seen;
        r.field_width = width_sum;
        r.has_precision = prec_on;
        r.precision_value = prec_sum;
        r.length_mask = len_bits;
        r.conversion = conv;
        r.found = hit;
        r.position = byte_pos;
        parsed_specs.push_back(r);
        clear_spec();
    endtask

    // advance the predicted parser by one format byte
    task automatic parse_byte(logic [7:0] c);
        logic consumed;
        consumed = 1'b0;
        case (spec_mode)
            MODE_PEND_H:
            begin
                spec_mode = MODE_IDLE;
                if (c == CH_H)
                begin
                    len_bits[LN_HH] = 1'b1;
                    consumed = 1'b1;
                end
                else
                    len_bits[LN_H] = 1'b1;
            end
            MODE_PEND_L:
            begin
                spec_mode = MODE_IDLE;
                if (c == CH_L)
                begin
                    len_bits[LN_LL] = 1'b1;
                    consumed = 1'b1;
                end
                else
                    len_bits[LN_L] = 1'b1;
            end
            MODE_WIDTH:
            begin
                if (is_digit(c))
                begin
                    width_sum = add_digit(width_sum, c);
                    consumed = 1'b1;
                end
                else
                    spec_mode = MODE_IDLE;
            end
            MODE_PREC:
            begin
                if (is_digit(c))
                begin
                    prec_sum = add_digit(prec_sum, c);
                    consumed = 1'b1;
                end
                else if (c == CH_DOT)
                    consumed = 1'b1;
                else
                    spec_mode = MODE_IDLE;
            end
            default:
                spec_mode = MODE_IDLE;
        endcase

        // byte not absorbed by the current mode: decode it fresh
        if (!consumed)
        begin
            if (c == CH_NUL)
            begin
                close_spec(CH_NUL, 1'b0);
                return;
            end
            else if (c == CH_MINUS)
                minus_seen = 1'b1;
            else if (c == CH_PLUS)
                plus_seen = 1'b1;
            else if (c == CH_HASH)
                hash_seen = 1'b1;
            else if (c == CH_SPACE)
                space_seen = 1'b1;
            else if (is_digit(c))
            begin
                if (c == CH_ZERO)
                    zero_seen = 1'b1;
                else
                    width_sum = add_digit(width_sum, c);
                spec_mode = MODE_WIDTH;
            end
            else if (c == CH_DOT)
            begin
                prec_on = 1'b1;
                spec_mode = MODE_PREC;
            end
            else if (c == CH_H)
                spec_mode = MODE_PEND_H;
            else if (c == CH_L)
                spec_mode = MODE_PEND_L;
            else if (c == CH_J)
                len_bits[LN_J] = 1'b1;
            else if (c == CH_Z)
                len_bits[LN_Z] = 1'b1;
            else
            begin
                close_spec(c, 1'b1);
                return;
            end
        end
        if (byte_pos != '1)
            byte_pos = byte_pos + 1'b1;
    endtask

    task automatic report_mismatch(string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("spec %0d %s got %0h want %0h",
                                      specs_checked, name, got, want));
    endtask

    task automatic push_text(string s);
        foreach (s[i])
            format_bytes.push_back(s[i]);
    endtask

    task automatic push_digits(int count);
        repeat (count)
            format_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic push_flags(int count);
        logic [7:0] flag_set[4];
        flag_set = '{CH_MINUS, CH_PLUS, CH_HASH, CH_SPACE};
        repeat (count)
            format_bytes.push_back(flag_set[$urandom_range(0, 3)]);
    endtask

    // one spec: mostly well-formed, some noise, now and then a very long one
    task automatic push_spec(bit long_run);
        int         shape;
        logic [7:0] b;
        shape = $urandom_range(0, 99);
        if (shape < 12 && !long_run)
        begin
            repeat ($urandom_range(1, 16))
                format_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end

        // long filler so the byte index saturates
        if (long_run || shape < 14)
            repeat ($urandom_range(250, 300))
                format_bytes.push_back(filler_chars[$urandom_range(0, filler_chars.len() - 1)]);

        push_flags($urandom_range(0, 3));

        // width, sometimes zero padded, sometimes split or long enough to clamp
        if ($urandom_range(0, 1))
        begin
            if ($urandom_range(0, 3) == 0)
                format_bytes.push_back(CH_ZERO);
            push_digits(($urandom_range(0, 7) == 0) ? $urandom_range(5, 9)
                                                     : $urandom_range(1, 3));
            if ($urandom_range(0, 7) == 0)
            begin
                push_flags(1);
                push_digits($urandom_range(1, 2));
            end
        end

        // precision, with stray extra dots now and then
        if ($urandom_range(0, 2) == 0)
        begin
            format_bytes.push_back(CH_DOT);
            if ($urandom_range(0, 5) == 0)
                format_bytes.push_back(CH_DOT);
            push_digits(($urandom_range(0, 7) == 0) ? $urandom_range(5, 9)
                                                     : $urandom_range(0, 3));
            if ($urandom_range(0, 7) == 0)
            begin
                format_bytes.push_back(CH_DOT);
                push_digits($urandom_range(0, 2));
            end
        end

        // length modifier
        case ($urandom_range(0, 9))
            0: push_text("h");
            1: push_text("hh");
            2: push_text("l");
            3: push_text("ll");
            4: push_text("j");
            5: push_text("z");
            6: push_text("lj");
            default: ;
        endcase

        // ending byte
        shape = $urandom_range(0, 99);
        if (shape < 15)
            format_bytes.push_back(CH_NUL);
        else if (shape < 65)
            format_bytes.push_back(conv_letters[$urandom_range(0, conv_letters.len() - 1)]);
        else
        begin
            do
                b = 8'($urandom_range(1, 255));
            while (b inside {CH_SPACE, CH_HASH, CH_PLUS, CH_MINUS, CH_DOT,
                             [CH_ZERO:CH_NINE], CH_H, CH_J, CH_L, CH_Z});
            format_bytes.push_back(b);
        end
    endtask

    // cycle count, idle-pattern windows and the run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count % 256 == 0)
        begin
            send_calm <= ($urandom_range(0, 3) == 0);
            recv_calm <= ($urandom_range(0, 3) == 0);
        end
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // input driver: holds each byte until it is taken, then maybe idles
    int send_gap = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_char <= CH_NUL;
            send_gap = 0;
            clear_spec();
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                parse_byte(in_char);
                bytes_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    in_valid <= 1'b0;
                    send_gap--;
                end
                else if (format_bytes.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_char <= format_bytes.pop_front();
                    send_gap = pick_gap(send_calm);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor and output stall pattern
    int stall_left = 0;

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        spec_result_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (parsed_specs.size() == 0)
                    report_mismatch("result beat with no spec pending");
                else
                begin
                    want = parsed_specs.pop_front();
                    compare_field("left_align", left_align, want.left_align);
                    compare_field("force_sign", force_sign, want.force_sign);
                    compare_field("alt_form", alt_form, want.alt_form);
                    compare_field("space_sign", space_sign, want.space_sign);
                    compare_field("zero_pad", zero_pad, want.zero_pad);
                    compare_field("field_width", field_width, want.field_width);
                    compare_field("has_precision", has_precision, want.has_precision);
                    compare_field("precision_value", precision_value, want.precision_value);
                    compare_field("length_mask", length_mask, want.length_mask);
                    compare_field("conversion", conversion, want.conversion);
                    compare_field("found", found, want.found);
                    compare_field("position", position, want.position);
                    specs_checked++;
                end
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                stall_left = pick_gap(recv_calm);
            end
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        // directed: all flags with zero pad and hh, dots and single l,
        // width across runs with j z ll and a high ending byte,
        // pending h then NUL, NUL right after dots
        push_text("-+# 07hhd");
        push_text(".2.5lf");
        push_text("5-3jzll");
        format_bytes.push_back(8'hFF);
        push_text("h");
        format_bytes.push_back(CH_NUL);
        push_text("..");
        format_bytes.push_back(CH_NUL);

        push_spec(1'b1);
        while (format_bytes.size() < RANDOM_BYTES)
            push_spec(1'b0);
        total_bytes = format_bytes.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (bytes_taken < total_bytes || parsed_specs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
